// ----- hdl/blr_pkg.sv -----
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other file in hdl/ imports this package.
package blr_pkg;

  localparam int unsigned CoordW  = 11;
  localparam int unsigned DeltaW  = 12;
  localparam int unsigned ErrW    = 13;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned PixXW   = 9;
  localparam int unsigned PixYW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic [PixXW-1:0]   WidthReset  = 9'd320;
  localparam logic [PixYW-1:0]   HeightReset = 8'd240;
  localparam logic signed [ErrW-1:0] ErrMax  = 13'sd4095;

  // Command codes carried in the cmd field
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  // Walker state produced by the line setup
  typedef struct packed {
    logic                     steep;
    logic signed [CoordW-1:0] major_pos;
    logic signed [CoordW-1:0] major_end;
    logic [CoordW-1:0]        minor_pos;
    logic [DeltaW-1:0]        major_delta;
    logic [DeltaW-1:0]        minor_delta;
    logic signed [ErrW-1:0]   err_init;
    logic                     minor_step_neg;
  } line_t;

endpackage

// ----- hdl/blr_setup.sv -----
// Line setup: steepness test, clamp to screen size, axis swap and endpoint ordering.
// Purely combinational; depends on blr_pkg.
module blr_setup (
  input  logic signed [blr_pkg::CoordW-1:0] start_x_i,
  input  logic signed [blr_pkg::CoordW-1:0] start_y_i,
  input  logic signed [blr_pkg::CoordW-1:0] end_x_i,
  input  logic signed [blr_pkg::CoordW-1:0] end_y_i,
  input  logic [blr_pkg::PixXW-1:0]         screen_width_i,
  input  logic [blr_pkg::PixYW-1:0]         screen_height_i,
  output blr_pkg::line_t                    line_o
);
  import blr_pkg::*;

  logic signed [DeltaW-1:0] ax, ay, bx, by;
  logic signed [DeltaW-1:0] dx, dy;
  logic [DeltaW-1:0]        adx, ady;
  logic signed [DeltaW-1:0] w_s, h_s;
  logic signed [DeltaW-1:0] cax, cay, cbx, cby;
  logic signed [DeltaW-1:0] p0, q0, p1, q1;
  logic signed [DeltaW-1:0] maj0, min0, maj1, min1;
  logic signed [DeltaW-1:0] dmin;
  logic [DeltaW-1:0]        mdelta;
  logic                     steep;

  always_comb begin
    ax = DeltaW'(start_x_i);
    ay = DeltaW'(start_y_i);
    bx = DeltaW'(end_x_i);
    by = DeltaW'(end_y_i);
    dx = bx - ax;
    dy = by - ay;
    adx = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
    ady = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);
    // steepness is judged on the unclamped endpoints
    steep = ady > adx;

    w_s = $signed({3'b000, screen_width_i});
    h_s = $signed({4'b0000, screen_height_i});
    cax = (ax > w_s) ? w_s : ax;
    cbx = (bx > w_s) ? w_s : bx;
    cay = (ay > h_s) ? h_s : ay;
    cby = (by > h_s) ? h_s : by;

    p0 = steep ? cay : cax;
    q0 = steep ? cax : cay;
    p1 = steep ? cby : cbx;
    q1 = steep ? cbx : cby;

    if (p0 > p1) begin
      maj0 = p1;
      min0 = q1;
      maj1 = p0;
      min1 = q0;
    end else begin
      maj0 = p0;
      min0 = q0;
      maj1 = p1;
      min1 = q1;
    end

    mdelta = DeltaW'(maj1 - maj0);
    dmin   = min1 - min0;

    line_o.steep          = steep;
    line_o.major_pos      = maj0[CoordW-1:0];
    line_o.major_end      = maj1[CoordW-1:0];
    line_o.minor_pos      = min0[CoordW-1:0];
    line_o.major_delta    = mdelta;
    line_o.minor_delta    = dmin[DeltaW-1] ? DeltaW'(-dmin) : DeltaW'(dmin);
    line_o.err_init       = ErrW'(0) - $signed({2'b00, mdelta[DeltaW-1:1]});
    line_o.minor_step_neg = !(min0 < min1);
  end

endmodule

// ----- hdl/blr_core.sv -----
// Line walker: holds the Bresenham state, steps it once per tick and registers the pixel.
// Depends on blr_pkg.
module blr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  blr_pkg::cmd_e                 cmd_i,
  input  blr_pkg::line_t                line_i,
  input  logic [blr_pkg::ColorW-1:0]    color_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [blr_pkg::PixXW-1:0]     pixel_x_o,
  output logic [blr_pkg::PixYW-1:0]     pixel_y_o,
  output logic [blr_pkg::ColorW-1:0]    pixel_color_o,
  output logic                          last_pixel_o
);
  import blr_pkg::*;

  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  line_t                    st_q, st_d;
  logic [ColorW-1:0]        color_q, color_d;
  logic [PixXW-1:0]         px_q, px_d;
  logic [PixYW-1:0]         py_q, py_d;
  logic [ColorW-1:0]        pcol_q, pcol_d;
  logic                     plast_q, plast_d;

  logic                     emit;
  logic                     last;
  logic [CoordW-1:0]        maj_u;
  logic signed [ErrW:0]     e_sum;
  logic signed [ErrW-1:0]   e_sat;

  always_comb begin
    emit  = fire_i && (cmd_i == CMD_TICK) && busy_q;
    last  = (st_q.major_pos == st_q.major_end);
    maj_u = st_q.major_pos;

    e_sum = $signed({st_q.err_init[ErrW-1], st_q.err_init})
          + $signed({2'b00, st_q.minor_delta});
    e_sat = (e_sum > $signed({1'b0, ErrMax})) ? ErrMax : e_sum[ErrW-1:0];

    busy_d  = busy_q;
    st_d    = st_q;
    color_d = color_q;
    px_d    = px_q;
    py_d    = py_q;
    pcol_d  = pcol_q;
    plast_d = plast_q;

    if (fire_i && (cmd_i == CMD_START)) begin
      // replace any line in progress
      st_d    = line_i;
      color_d = color_i;
      busy_d  = 1'b1;
    end else if (emit) begin
      px_d    = st_q.steep ? st_q.minor_pos[PixXW-1:0] : maj_u[PixXW-1:0];
      py_d    = st_q.steep ? maj_u[PixYW-1:0] : st_q.minor_pos[PixYW-1:0];
      pcol_d  = color_q;
      plast_d = last;
      if (e_sat > 0) begin
        st_d.minor_pos = st_q.minor_step_neg ? st_q.minor_pos - 1'b1
                                             : st_q.minor_pos + 1'b1;
        st_d.err_init  = e_sat - $signed({1'b0, st_q.major_delta});
      end else begin
        st_d.err_init  = e_sat;
      end
      if (last) begin
        busy_d = 1'b0;
      end else begin
        st_d.major_pos = st_q.major_pos + 1'b1;
      end
    end

    // hold a stalled beat; the top only fires when this register can take a new one
    out_valid_d = (out_valid_q && out_stall_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      color_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      color_q     <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    pcol_q  <= pcol_d;
    plast_q <= plast_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign last_pixel_o  = plast_q;

endmodule

// ----- hdl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: input register, screen-size registers,
// line setup and line walker. Depends on blr_pkg, blr_setup and blr_core.
//
// A beat with cmd = start loads two endpoints and a colour and produces no pixel; each
// later tick beat produces one pixel until the beat flagged last_pixel, after which the
// block is idle and ticks are dropped. A start while a line is being drawn replaces it.
// Endpoints above the screen size are clamped to the size itself (not size minus one);
// steepness is judged before clamping. Every beat is registered on entry and its pixel
// comes out of the walker's result register. The sustained rate is one beat per cycle
// while out_stall_i is low, as the walker's error update is combinational. The input
// side stalls only while a finished pixel is held back by out_stall_i. Write
// screen_width (index 0) and screen_height (index 1) only while idle.
module bresenham_line_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [blr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [blr_pkg::CfgDataW-1:0]     cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic signed [blr_pkg::CoordW-1:0] start_x_i,
  input  logic signed [blr_pkg::CoordW-1:0] start_y_i,
  input  logic signed [blr_pkg::CoordW-1:0] end_x_i,
  input  logic signed [blr_pkg::CoordW-1:0] end_y_i,
  input  logic [blr_pkg::ColorW-1:0]       line_color_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [blr_pkg::PixXW-1:0]        pixel_x_o,
  output logic [blr_pkg::PixYW-1:0]        pixel_y_o,
  output logic [blr_pkg::ColorW-1:0]       pixel_color_o,
  output logic                             last_pixel_o
);
  import blr_pkg::*;

  // screen size registers
  logic [PixXW-1:0] width_q;
  logic [PixYW-1:0] height_q;

  // input register
  logic                     in_valid_q, in_valid_d;
  cmd_e                     cmd_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [ColorW-1:0]        color_q;

  logic   advance;
  logic   fire;
  logic   in_accept;
  line_t  line;

  // the walker can take a beat whenever its result register is empty or draining
  assign advance    = !out_valid_o || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthReset;
      height_q   <= HeightReset;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[PixXW-1:0];
          CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[PixYW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
      color_q <= line_color_i;
    end
  end

  blr_setup u_setup (
    .start_x_i       (sx_q),
    .start_y_i       (sy_q),
    .end_x_i         (ex_q),
    .end_y_i         (ey_q),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .line_o          (line)
  );

  blr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .cmd_i         (cmd_q),
    .line_i        (line),
    .color_i       (color_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ----- test/bresenham_line_rasterizer_tb.sv -----
// Self-checking testbench for bresenham_line_rasterizer: drives start and tick beats, predicts
// every pixel from its own line walker and checks the pixel stream field by field.
// Depends on blr_pkg and the rasterizer RTL only.
module bresenham_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int QuietLimit = 2000;   // cycles with no beat on either side before giving up
  localparam int PhaseBeats = 100;    // random beats per screen size

  // One input beat as the sender holds it
  typedef struct {
    cmd_e                     cmd;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic [ColorW-1:0]        color;
  } beat_t;

  // One pixel as the rasterizer should emit it
  typedef struct {
    logic [PixXW-1:0]  x;
    logic [PixYW-1:0]  y;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_t;

  // DUT connections; the inputs are all known from time zero
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     cmd_i = 1'b0;
  logic signed [CoordW-1:0] start_x_i = '0;
  logic signed [CoordW-1:0] start_y_i = '0;
  logic signed [CoordW-1:0] end_x_i = '0;
  logic signed [CoordW-1:0] end_y_i = '0;
  logic [ColorW-1:0]        line_color_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PixXW-1:0]         pixel_x_o;
  logic [PixYW-1:0]         pixel_y_o;
  logic [ColorW-1:0]        pixel_color_o;
  logic                     last_pixel_o;

  bresenham_line_rasterizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_color_i  (line_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

  // Beats waiting to be sent, and pixels the walker below has promised
  beat_t  feed_q[$];
  pixel_t pixel_q[$];
  beat_t  beat_cur;

  // Mirror of the screen-size registers
  logic [PixXW-1:0] scr_w = WidthReset;
  logic [PixYW-1:0] scr_h = HeightReset;

  // Mirror of the line walker
  bit                 line_busy;
  bit                 line_steep;
  int                 major_at;
  int                 major_stop;
  logic [CoordW-1:0]  minor_at;
  int                 major_span;
  int                 minor_span;
  int                 err_term;
  bit                 minor_down;
  logic [ColorW-1:0]  line_color_q;

  // Bookkeeping
  int beats_fed;
  int beats_taken;
  int starts_seen;
  int pixels_checked;
  int screens;
  int mismatches;
  int quiet_cycles;
  int send_gap;
  int stall_left;
  bit send_calm;
  bit recv_calm;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the walker mirror by one accepted beat; queue the pixel it yields, if any.
  function automatic void rasterize_beat(beat_t b);
    int     ax, ay, bx, by, t, nxt, w, h;
    pixel_t px;
    logic [CoordW-1:0] maj;
    if (b.cmd == CMD_START) begin
      ax = $signed(b.sx);
      ay = $signed(b.sy);
      bx = $signed(b.ex);
      by = $signed(b.ey);
      w  = int'(scr_w);
      h  = int'(scr_h);
      // steepness is judged on the raw endpoints, before any clamp
      line_steep = mag(by - ay) > mag(bx - ax);
      // clamp to the size itself; no lower clamp
      if (ax > w) ax = w;
      if (bx > w) bx = w;
      if (ay > h) ay = h;
      if (by > h) by = h;
      if (line_steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      major_at     = ax;
      major_stop   = bx;
      minor_at     = ay[CoordW-1:0];
      major_span   = bx - ax;
      minor_span   = mag(by - ay);
      err_term     = -(major_span / 2);
      // equal minor endpoints count as a downward step that is never taken
      minor_down   = !(ay < by);
      line_color_q = b.color;
      line_busy    = 1'b1;
      starts_seen++;
    end else if (line_busy) begin
      maj      = major_at[CoordW-1:0];
      px.x     = line_steep ? minor_at[PixXW-1:0] : maj[PixXW-1:0];
      px.y     = line_steep ? maj[PixYW-1:0] : minor_at[PixYW-1:0];
      px.color = line_color_q;
      px.last  = (major_at == major_stop);
      pixel_q.push_back(px);
      // the error sum saturates once a clamp has left the minor span above the major span
      nxt = err_term + minor_span;
      if (nxt > ErrMax) nxt = ErrMax;
      if (nxt > 0) begin
        minor_at = minor_down ? minor_at - 1'b1 : minor_at + 1'b1;
        nxt -= major_span;
      end
      err_term = nxt;
      if (px.last) line_busy = 1'b0;
      else major_at++;
    end
    // a tick while idle yields nothing
  endfunction

  task automatic queue_beat(cmd_e cmd, logic signed [CoordW-1:0] sx,
                            logic signed [CoordW-1:0] sy, logic signed [CoordW-1:0] ex,
                            logic signed [CoordW-1:0] ey, logic [ColorW-1:0] color);
    beat_t b;
    b.cmd   = cmd;
    b.sx    = sx;
    b.sy    = sy;
    b.ex    = ex;
    b.ey    = ey;
    b.color = color;
    feed_q.push_back(b);
    beats_fed++;
  endtask

  // Ticks carry random payload so the ignored fields toggle too
  task automatic queue_tick();
    queue_beat(CMD_TICK, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
               CoordW'($urandom), ColorW'($urandom));
  endtask

  function automatic logic signed [CoordW-1:0] coord_near(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return v[CoordW-1:0];
  endfunction

  // One start followed by a run of ticks. Most lines are short so that they finish and
  // leave some idle ticks behind; a few span the whole field and get cut off by the next start.
  task automatic queue_random_line();
    logic signed [CoordW-1:0] ax, ay, bx, by;
    int kind, span, n;
    kind = $urandom_range(0, 9);
    span = (kind == 0) ? 1024 : $urandom_range(0, 12);
    if (kind == 1 || kind == 2) begin
      // sit on the clamp boundary
      ax = coord_near(scr_w, 6);
      ay = coord_near(scr_h, 6);
    end else begin
      ax = CoordW'($urandom_range(0, 2047));
      ay = CoordW'($urandom_range(0, 2047));
    end
    if (kind == 0) begin
      bx = CoordW'($urandom_range(0, 2047));
      by = CoordW'($urandom_range(0, 2047));
      n  = $urandom_range(1, 30);
    end else begin
      bx = coord_near(ax, span);
      by = coord_near(ay, span);
      n  = $urandom_range(0, 2 * span + 4);
    end
    queue_beat(CMD_START, ax, ay, bx, by, ColorW'($urandom_range(0, 65535)));
    repeat (n) queue_tick();
  endtask

  // Hold until every queued beat is taken and every pixel is back, then let the
  // input register and the walker's result register empty of idle ticks that produce nothing.
  task automatic drain();
    while (beats_taken != beats_fed || pixel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both screen-size registers; only called while the block is idle.
  task automatic set_screen(logic [PixXW-1:0] w, logic [PixYW-1:0] h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCREEN_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SCREEN_HEIGHT;
    cfg_data_i <= {1'b0, h};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    scr_w = w;
    scr_h = h;
    screens++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: present one beat at a time from feed_q, with a random gap after each beat.
  // A stalled beat is left untouched; the predictor runs on the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rasterize_beat(beat_cur);
        beats_taken++;
        send_gap = send_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      end else if (!in_valid_i && send_gap != 0) begin
        send_gap--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap == 0 && feed_q.size() != 0) begin
          beat_cur = feed_q.pop_front();
          in_valid_i   <= 1'b1;
          cmd_i        <= beat_cur.cmd;
          start_x_i    <= beat_cur.sx;
          start_y_i    <= beat_cur.sy;
          end_x_i      <= beat_cur.ex;
          end_y_i      <= beat_cur.ey;
          line_color_i <= beat_cur.color;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each pixel beat with the oldest promise, then stall for a random while.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d color=%0h last=%0b",
                   $time, pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o);
        end else begin
          pixel_t want;
          want = pixel_q.pop_front();
          check_field("pixel_x", want.x, pixel_x_o);
          check_field("pixel_y", want.y, pixel_y_o);
          check_field("pixel_color", want.color, pixel_color_o);
          check_field("last_pixel", want.last, last_pixel_o);
          pixels_checked++;
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        out_stall_i <= (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("%0t: watchdog: no beat for %0d cycles, %0d pixels outstanding",
                 $time, QuietLimit, pixel_q.size());
        $display("bresenham_line_rasterizer_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines at the reset screen size (320 x 240)
    queue_tick();                                          // tick while idle
    queue_beat(CMD_START, 5, 5, 5, 5, 16'hFFFF);          // single-point line
    queue_tick();
    queue_tick();                                          // idle again after the flag
    queue_beat(CMD_START, -1024, -1024, 1023, 1023, 16'h0000);  // field extremes, clamped
    queue_tick();
    queue_tick();
    queue_beat(CMD_START, 20, 22, 18, 26, 16'hA5A5);      // replaces a busy line; steep,
    repeat (5) queue_tick();                               // minor axis stepping down
    queue_beat(CMD_START, -3, 7, -7, 7, 16'h1234);        // flat line, reversed ends
    repeat (3) queue_tick();
    // Clamp leaves a minor span far above the major span: error sum saturates
    queue_beat(CMD_START, 312, -700, 1023, -2, 16'h5A5A);
    repeat (9) queue_tick();
    drain();

    // Random lines over several screen sizes, the extremes first. Each phase ends on a
    // single-point line so the walker is idle, and drain holds the sender until every
    // promised pixel is back before the registers change.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_screen(9'd0, 8'd0);
        1: set_screen(9'd511, 8'd255);
        2: set_screen(9'd0, 8'd255);
        3: set_screen(9'd511, 8'd0);
        default: set_screen(PixXW'($urandom_range(0, 511)), PixYW'($urandom_range(0, 255)));
      endcase
      for (int stop = beats_fed + PhaseBeats; beats_fed < stop; ) queue_random_line();
      queue_beat(CMD_START, 0, 0, 0, 0, ColorW'($urandom_range(0, 65535)));
      queue_tick();
      drain();
    end

    $display("Run covered %0d line starts, %0d pixels checked, %0d screen sizes written.",
             starts_seen, pixels_checked, screens);
    if (mismatches == 0) begin
      $display("bresenham_line_rasterizer_tb: done, clean");
    end else begin
      $display("bresenham_line_rasterizer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/blr_pkg.sv
hdl/blr_setup.sv
hdl/blr_core.sv
hdl/bresenham_line_rasterizer.sv
test/bresenham_line_rasterizer_tb.sv
